/* rtl/core/c8wh_pkg.sv */
// Shared types and constants for the Crap8 word hash.
// No dependencies; used by every module of the block.
`default_nettype none

package c8wh_pkg;

    localparam logic [31:0] MUL_M = 32'h83d2e73b;
    localparam logic [31:0] MUL_N = 32'h97e1cc59;

    // One classified word, as it waits between front and back.
    typedef struct packed {
        logic        first;
        logic        nz;
        logic        last;
        logic [31:0] init_h;
        logic [31:0] init_k;
        logic [31:0] prod_lo;
        logic [31:0] prod_hi;
    } c8wh_entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } c8wh_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/crap8_word_hash.sv */
// Top level of the Crap8 word hash over little-endian 32-bit words.
// Instantiates c8wh_front, c8wh_queue and c8wh_back; uses c8wh_pkg.
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    data_word, valid_bytes, last_word,
//                                  seed_value, total_length
// output    out_valid / out_ready  hash_value
//
// While in_ready is high the front takes one input beat per cycle into a holding
// stage, masks the word and forms word * m there, and pushes the result into a
// short queue. The back mixes one queued word per cycle in BK_MIX while the queue
// is not empty, through the h * m multiplier on its feedback loop; after a last
// word it passes through BK_FOLD for the (h ^ k) * n fold and BK_FIN to load the
// output register. Reset empties the queue and the holding stage and waits for
// the first word of a message. A stalled output holds only the back; the front
// keeps accepting beats until the queue and its holding stage are full.
module crap8_word_hash
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        last_word,
    input  wire logic [31:0] seed_value,
    input  wire logic [31:0] total_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);

    c8wh_pkg::c8wh_qstat_t q_stat;
    c8wh_pkg::c8wh_entry_t push_entry;
    c8wh_pkg::c8wh_entry_t head_entry;
    logic                  push;
    logic                  pop;
    logic                  stage_valid;

    c8wh_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_word    (data_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .seed_value   (seed_value),
        .total_length (total_length),
        .q_stat       (q_stat),
        .push         (push),
        .push_entry   (push_entry),
        .stage_valid  (stage_valid)
    );

    c8wh_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    c8wh_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("queue push while full");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("queue pop while empty");

    // An accepted beat is held in the front stage on the next cycle.
    a_stage_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> stage_valid)
        else $error("accepted beat not held in front stage");

    // A full front stage with a full queue must stall the input.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && q_stat.full) |-> !in_ready)
        else $error("input ready while front and queue are full");

endmodule

`default_nettype wire

/* rtl/core/c8wh_front.sv */
// Front end of the Crap8 word hash: accepts input beats, masks the word,
// forms word * m and the start values, and pushes them to the queue. Uses c8wh_pkg.
`default_nettype none

module c8wh_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           data_word,
    input  wire logic [2:0]            valid_bytes,
    input  wire logic                  last_word,
    input  wire logic [31:0]           seed_value,
    input  wire logic [31:0]           total_length,
    input  wire c8wh_pkg::c8wh_qstat_t q_stat,
    output logic                       push,
    output c8wh_pkg::c8wh_entry_t      push_entry,
    output logic                       stage_valid
);

    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    logic        st_valid_reg, st_valid_next;
    logic        mid_reg, mid_next;
    logic [31:0] st_word_reg;
    logic        st_nz_reg;
    logic        st_last_reg;
    logic        st_first_reg;
    logic [31:0] st_h_reg;
    logic [31:0] st_k_reg;
    logic        accept;
    logic [63:0] prod;

    assign push     = st_valid_reg && !q_stat.full;
    assign in_ready = !st_valid_reg || !q_stat.full;
    assign accept   = in_valid && in_ready;

    // The first-word flag only depends on the last-word marks seen so far.
    always_comb
    begin
        st_valid_next = st_valid_reg;
        mid_next      = mid_reg;
        if (push)
        begin
            st_valid_next = 1'b0;
        end
        if (accept)
        begin
            st_valid_next = 1'b1;
            mid_next      = !last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            mid_reg      <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            mid_reg      <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_word_reg  <= data_word & byte_mask(valid_bytes);
            st_nz_reg    <= (valid_bytes != 3'd0);
            st_last_reg  <= last_word;
            st_first_reg <= !mid_reg;
            st_h_reg     <= total_length + seed_value;
            st_k_reg     <= c8wh_pkg::MUL_N + total_length;
        end
    end

    assign prod = 64'(st_word_reg) * 64'(c8wh_pkg::MUL_M);

    always_comb
    begin
        push_entry.first   = st_first_reg;
        push_entry.nz      = st_nz_reg;
        push_entry.last    = st_last_reg;
        push_entry.init_h  = st_h_reg;
        push_entry.init_k  = st_k_reg;
        push_entry.prod_lo = prod[31:0];
        push_entry.prod_hi = prod[63:32];
    end

    assign stage_valid = st_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/c8wh_queue.sv */
// Short FIFO of classified words between the front and back of the hash.
// Uses c8wh_pkg for the entry and status types.
`default_nettype none

module c8wh_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire c8wh_pkg::c8wh_entry_t push_entry,
    input  wire logic                  pop,
    output c8wh_pkg::c8wh_entry_t      head_entry,
    output c8wh_pkg::c8wh_qstat_t      q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    c8wh_pkg::c8wh_entry_t store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry   = store_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* rtl/core/c8wh_back.sv */
// Back end of the Crap8 word hash: mixes queued words into h and k,
// runs the final fold and holds the result beat. Uses c8wh_pkg.
`default_nettype none

module c8wh_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire c8wh_pkg::c8wh_entry_t head_entry,
    input  wire c8wh_pkg::c8wh_qstat_t q_stat,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [31:0]                hash_value
);

    typedef enum logic [2:0] {
        BK_MIX  = 3'b001,
        BK_FOLD = 3'b010,
        BK_FIN  = 3'b100
    } bk_state_t;

    bk_state_t   state_reg, state_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [63:0] fold_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] hash_reg;
    logic        load_out;
    logic [31:0] base_h;
    logic [31:0] base_k;
    logic [31:0] hm;
    logic [63:0] fold_prod;

    assign base_h    = head_entry.first ? head_entry.init_h : h_reg;
    assign base_k    = head_entry.first ? head_entry.init_k : k_reg;
    assign hm        = base_h * c8wh_pkg::MUL_M;
    assign fold_prod = 64'(h_reg ^ k_reg) * 64'(c8wh_pkg::MUL_N);

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            BK_MIX:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (head_entry.nz)
                    begin
                        h_next = hm ^ head_entry.prod_hi;
                        k_next = base_k ^ head_entry.prod_lo;
                    end
                    else
                    begin
                        h_next = base_h;
                        k_next = base_k;
                    end
                    if (head_entry.last)
                    begin
                        state_next = BK_FOLD;
                    end
                end
            end
            BK_FOLD:
            begin
                state_next = BK_FIN;
            end
            BK_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    k_next         = k_reg ^ fold_reg[31:0] ^ fold_reg[63:32];
                    state_next     = BK_MIX;
                end
            end
            default:
            begin
                state_next = BK_MIX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_MIX;
            h_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_FOLD)
        begin
            fold_reg <= fold_prod;
        end
        if (load_out)
        begin
            hash_reg <= k_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

`default_nettype wire
